@@ hw/rtl/text_console_writer_macros.svh @@
// Assertion macros for the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define TCW_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
// Types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam logic [7:0]  LINE_BREAK = 8'h0A;
  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  COLOR_RESET = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_WRITE,
    ST_DIVIDE,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
  } out_beat_t;

endpackage

`default_nettype wire

@@ hw/rtl/text_console_writer.sv @@
// Steps from input beat to result beat: put and erase execute, sweep the cursor row if it
// is blank, write the cell and finish; read executes, divides the address by COLUMNS, reads
// the cell unless its row is blank, and finishes; clear, line break, erase at column 0 and
// an out-of-range read execute and finish. One command at a time; out_stall holds the finish.
// Reset (synchronous, active low) marks every row blank, homes the cursor and sets the
// color to 0x07; the cell RAM itself is not swept.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_beat_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_beat_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data
);

  `include "text_console_writer_macros.svh"

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int POS_W      = ROW_W + COL_W;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  state_t               state_r, state_nxt;
  in_beat_t             cmd_r, cmd_nxt;
  logic [7:0]           color_r;
  logic [ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]     cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]     base_r, base_nxt;
  logic [ROWS-1:0]      blank_rows_r, blank_rows_nxt;
  logic [COL_W-1:0]     sweep_col_r, sweep_col_nxt;
  logic [10:0]          rem_r, rem_nxt;
  logic [ROW_W-1:0]     qrow_r, qrow_nxt;
  logic [15:0]          value_r, value_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic [ROW_W-1:0]     sel_row;
  logic [ROW_W:0]       phys_sum;
  logic [ROW_W-1:0]     phys_row;
  logic                 row_blank;
  logic [COL_W-1:0]     col_sel;
  logic [POS_W-1:0]     cursor_lin;
  logic                 read_in_range;
  logic                 rem_ge_cols;
  logic                 do_next_line;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [15:0]          ram_wdata;
  logic [15:0]          ram_rdata;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // The display is a ring of rows: logical row r lives in physical row r + base.
  assign sel_row   = (state_r == ST_DIVIDE) ? qrow_r : cur_row_r;
  assign phys_sum  = {1'b0, sel_row} + {1'b0, base_r};
  assign phys_row  = (phys_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(phys_sum - (ROW_W + 1)'(ROWS))
                                                      : ROW_W'(phys_sum);
  assign row_blank = blank_rows_r[phys_row];

  assign col_sel = (state_r == ST_SWEEP)  ? sweep_col_r :
                   (state_r == ST_DIVIDE) ? COL_W'(rem_r) : cur_col_r;

  assign ram_addr   = ADDR_W'(POS_W'(phys_row) * POS_W'(COLUMNS) + POS_W'(col_sel));
  assign cursor_lin = POS_W'(cur_row_r) * POS_W'(COLUMNS) + POS_W'(cur_col_r);

  assign read_in_range = 32'(cmd_r.cell_address) < 32'(CELL_COUNT);
  assign rem_ge_cols   = rem_r >= 11'(COLUMNS);

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_r.opcode)
          OP_PUT: begin
            if (cmd_r.char_code == LINE_BREAK) state_nxt = ST_FINISH;
            else state_nxt = row_blank ? ST_SWEEP : ST_WRITE;
          end
          OP_ERASE: begin
            if (cur_col_r == '0) state_nxt = ST_FINISH;
            else state_nxt = row_blank ? ST_SWEEP : ST_WRITE;
          end
          OP_READ: begin
            state_nxt = read_in_range ? ST_DIVIDE : ST_FINISH;
          end
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_SWEEP: begin
        if (sweep_col_r == COL_W'(COLUMNS - 1)) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_FINISH;
      ST_DIVIDE: begin
        if (!rem_ge_cols) state_nxt = row_blank ? ST_FINISH : ST_READ;
      end
      ST_READ: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    cmd_nxt        = cmd_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    base_nxt       = base_r;
    blank_rows_nxt = blank_rows_r;
    sweep_col_nxt  = sweep_col_r;
    rem_nxt        = rem_r;
    qrow_nxt       = qrow_r;
    value_nxt      = value_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_wdata      = BLANK_CELL;
    do_next_line   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) cmd_nxt = in_data;
      end
      ST_EXEC: begin
        value_nxt     = '0;
        rem_nxt       = cmd_r.cell_address;
        qrow_nxt      = '0;
        sweep_col_nxt = '0;
        case (cmd_r.opcode)
          OP_PUT: begin
            if (cmd_r.char_code == LINE_BREAK) do_next_line = 1'b1;
          end
          OP_ERASE: begin
            if (cur_col_r != '0) cur_col_nxt = cur_col_r - COL_W'(1);
          end
          OP_CLEAR: begin
            blank_rows_nxt = '1;
            cur_row_nxt    = '0;
            cur_col_nxt    = '0;
          end
          default: ;
        endcase
      end
      ST_SWEEP: begin
        ram_we        = 1'b1;
        ram_wdata     = BLANK_CELL;
        sweep_col_nxt = sweep_col_r + COL_W'(1);
        if (sweep_col_r == COL_W'(COLUMNS - 1)) blank_rows_nxt[phys_row] = 1'b0;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        if (cmd_r.opcode == OP_ERASE) begin
          ram_wdata = {color_r, SPACE_CHAR};
        end else begin
          ram_wdata = {color_r, cmd_r.char_code};
          if (cur_col_r == COL_W'(COLUMNS - 1)) do_next_line = 1'b1;
          else cur_col_nxt = cur_col_r + COL_W'(1);
        end
      end
      ST_DIVIDE: begin
        if (rem_ge_cols) begin
          rem_nxt  = rem_r - 11'(COLUMNS);
          qrow_nxt = qrow_r + ROW_W'(1);
        end else if (row_blank) begin
          value_nxt = BLANK_CELL;
        end
      end
      ST_READ: value_nxt = ram_rdata;
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_position = 11'(cursor_lin);
          out_data_nxt.cell_value      = value_r;
        end
      end
      default: ;
    endcase

    // At the bottom row a line break scrolls by rotating the ring; the old top row
    // becomes the new bottom row and reads blank until it is written.
    if (do_next_line) begin
      cur_col_nxt = '0;
      if (cur_row_r == ROW_W'(ROWS - 1)) begin
        blank_rows_nxt[base_r] = 1'b1;
        base_nxt = (base_r == ROW_W'(ROWS - 1)) ? '0 : base_r + ROW_W'(1);
      end else begin
        cur_row_nxt = cur_row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      color_r      <= COLOR_RESET;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      base_r       <= '0;
      blank_rows_r <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) color_r <= cfg_data;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      base_r       <= base_nxt;
      blank_rows_r <= blank_rows_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    sweep_col_r <= sweep_col_nxt;
    rem_r       <= rem_nxt;
    qrow_r      <= qrow_nxt;
    value_r     <= value_nxt;
    out_data_r  <= out_data_nxt;
  end

  `TCW_ASSERT_NOW(a_cursor_range, 1'b1,
    (cur_row_r <= ROW_W'(ROWS - 1)) && (cur_col_r <= COL_W'(COLUMNS - 1)),
    "cursor left the display")
  `TCW_ASSERT_NOW(a_write_row_filled, state_r == ST_WRITE, !row_blank,
    "cell write into a row that was never blanked")
  `TCW_ASSERT_NEXT(a_clear_homes, (state_r == ST_EXEC) && (cmd_r.opcode == OP_CLEAR),
    (blank_rows_r == '1) && (cur_row_r == '0) && (cur_col_r == '0),
    "clear did not home the cursor and blank every row")
  `TCW_ASSERT_NOW(a_result_from_finish, $rose(out_valid_r), $past(state_r == ST_FINISH),
    "result beat raised outside the finish step")

endmodule

`default_nettype wire

@@ hw/rtl/tcw_ram.sv @@
// Single-port synchronous RAM with a registered read.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

@@ sim/console_screen_monitor.sv @@
// Screen and cursor predictor with result comparison for the text console writer.
`timescale 1ns / 1ps

module console_screen_monitor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire in_beat_t   in_data,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire out_beat_t  out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  output int              errors,
  output int              outstanding
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [15:0] screen [CELLS];
  int          row;
  int          col;
  logic [7:0]  color;
  out_beat_t   pending_results [$];

  function automatic void blank_screen();
    foreach (screen[i]) screen[i] = BLANK_CELL;
  endfunction

  // Moves to column 0 of the next row; below the last row the screen scrolls up
  // and the new bottom row is blank with the default attribute, not the color.
  function automatic void line_feed();
    col = 0;
    row++;
    if (row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
      row = ROWS - 1;
    end
  endfunction

  function automatic out_beat_t apply_console_command(in_beat_t cmd);
    out_beat_t res;
    res.cell_value = '0;
    case (opcode_t'(cmd.opcode))
      OP_PUT: begin
        if (cmd.char_code == LINE_BREAK) begin
          line_feed();
        end else begin
          screen[row * COLUMNS + col] = {color, cmd.char_code};
          col++;
          if (col >= COLUMNS) line_feed();
        end
      end
      OP_ERASE: begin
        if (col != 0) begin
          col--;
          screen[row * COLUMNS + col] = {color, SPACE_CHAR};
        end
      end
      OP_CLEAR: begin
        blank_screen();
        row = 0;
        col = 0;
      end
      OP_READ: begin
        if (cmd.cell_address < CELLS) res.cell_value = screen[cmd.cell_address];
      end
      default: ;
    endcase
    res.cursor_position = 11'(row * COLUMNS + col);
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      blank_screen();
      row = 0;
      col = 0;
      color = COLOR_RESET;
      errors = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) color = cfg_data;
      // The result side is checked first so a stray beat is never matched
      // against a command accepted on the same edge.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, got cursor %0d cell %h", $time,
                   out_data.cursor_position, out_data.cell_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.cursor_position !== want.cursor_position) begin
            $display("%0t: cursor position expected %0d, got %0d", $time,
                     want.cursor_position, out_data.cursor_position);
            errors++;
          end
          if (out_data.cell_value !== want.cell_value) begin
            $display("%0t: cell value expected %h, got %h", $time,
                     want.cell_value, out_data.cell_value);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(apply_console_command(in_data));
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top: drives commands and color writes into the text console writer.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS = 1100;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  in_beat_t   in_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;
  int         errors;
  int         outstanding;
  int         idle_pct = 35;
  int         sent = 0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  console_screen_monitor #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) screen_monitor (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .errors(errors),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic send(input opcode_t op, input logic [7:0] ch, input logic [10:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, char_code: ch, cell_address: addr};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_put(input logic [7:0] ch);
    send(OP_PUT, ch, 11'($urandom_range(2047)));
  endtask

  task automatic send_read(input logic [10:0] addr);
    send(OP_READ, 8'($urandom_range(255)), addr);
  endtask

  // The color register is only written once every command has been answered.
  task automatic set_color(input logic [7:0] hue);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_we <= 1'b1;
    cfg_data <= hue;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [10:0] random_address();
    if ($urandom_range(99) < 10) return 11'($urandom_range(2047, CELLS));
    return 11'($urandom_range(CELLS - 1));
  endfunction

  // Mostly runs of text, some long enough to wrap, ended by line breaks so
  // the screen fills and scrolls; reads, erases, clears and noise mixed in.
  task automatic random_burst();
    int roll;
    int n;
    roll = $urandom_range(99);
    if (roll < 60) begin
      n = ($urandom_range(99) < 20) ? $urandom_range(60, 100) : $urandom_range(0, 20);
      repeat (n) send_put(8'($urandom_range(255)));
      if ($urandom_range(99) < 80) send_put(LINE_BREAK);
    end else if (roll < 66) begin
      repeat ($urandom_range(2, 10)) send_put(LINE_BREAK);
    end else if (roll < 84) begin
      repeat ($urandom_range(1, 6)) send_read(random_address());
    end else if (roll < 95) begin
      repeat ($urandom_range(1, 5))
        send(OP_ERASE, 8'($urandom_range(255)), 11'($urandom_range(2047)));
    end else if (roll < 96) begin
      send(OP_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
    end else begin
      send(opcode_t'($urandom_range(3)), 8'($urandom_range(255)), 11'($urandom_range(2047)));
    end
  endtask

  initial begin
    logic [7:0] hue;
    int goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Blank screen after reset, both ends of the store and past its end.
    send_read(11'd0);
    send_read(11'(CELLS - 1));
    send_read(11'(CELLS));
    send_read(11'd2047);
    // Erase at column 0 leaves everything as it is.
    send(OP_ERASE, 8'h00, 11'd0);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h41);
    send(OP_ERASE, 8'hFF, 11'd2047);
    send_read(11'd2);
    send_read(11'd1);
    send_put(LINE_BREAK);
    send_put(8'h0D);
    send_read(11'(COLUMNS));
    set_color(8'hFF);
    send_put(8'h5A);
    send(OP_ERASE, 8'h00, 11'd0);
    send_put(8'h7E);
    send_read(11'(COLUMNS + 1));
    // Clear keeps the color; the screen goes back to default blanks.
    set_color(8'h00);
    send_put(8'h20);
    send(OP_CLEAR, 8'hAA, 11'h555);
    send_read(11'd0);
    send_read(11'(COLUMNS + 1));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: hue = 8'($urandom_range(255));
        1: hue = 8'hFF;
        2: hue = 8'($urandom_range(255));
        default: hue = COLOR_RESET;
      endcase
      set_color(hue);
      // The second phase runs without any idle cycles on either side.
      idle_pct <= (p == 1) ? 0 : 35;
      goal = sent + RANDOM_ITEMS / 4;
      while (sent < goal) random_burst();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
sim/console_screen_monitor.sv
sim/tb_top.sv
